FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ptpb_pkg.sv
// Types and constants shared by the tile row to bitmap converter.
package ptpb_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned ADDR_W     = 13;
  localparam int unsigned PX_BITS    = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BANK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd1;

  localparam logic [1:0] BANK_SIZE_RESET = 2'd3;
  localparam logic [3:0] SCALE_RESET     = 4'd1;
  localparam logic [1:0] PIXEL_MASK      = 2'h3;

  // One classified tile row waiting for serialization
  typedef struct packed {
    logic [7:0]        plane_high;
    logic [7:0]        plane_low;
    logic              row_end;
    logic              sheet_end;
    logic [ADDR_W-1:0] addr;
  } ptpb_entry_t;

endpackage

FILE: hdl/ptpb_front.sv
// Front end: configuration registers, sheet position counters and item classification.
module ptpb_front #(
  parameter int unsigned MAX_SCALE = 10,
  parameter int unsigned SW        = $clog2(MAX_SCALE + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [ptpb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ptpb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  input  logic [7:0]                       plane_low_i,
  input  logic [7:0]                       plane_high_i,
  input  logic                             q_full_i,
  output logic                             in_stall_o,
  output logic                             push_o,
  output ptpb_pkg::ptpb_entry_t            entry_o,
  output logic [SW-1:0]                    scale_o
);
  import ptpb_pkg::*;

  logic [1:0]    bank_q, bank_d;
  logic [3:0]    scale_q, scale_d;
  logic          sec_q, sec_d;
  logic [3:0]    col_q, col_d;
  logic [3:0]    trow_q, trow_d;
  logic [2:0]    prow_q, prow_d;
  logic [SW-1:0] rrep_q, rrep_d;

  logic          accept;
  logic          dim16, two_sec;
  logic          col_last, row_done, rrep_last, sheet_done;
  logic [SW:0]   rrep_inc;
  logic [SW-1:0] s_eff;
  logic          restart;
  logic [3:0]    trow_top;
  logic [8:0]    tile_idx;

  // Hold input while the queue is full or a register write is presented
  assign in_stall_o = q_full_i || cfg_valid_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Clamp the scale register to 1..MAX_SCALE
  always_comb begin
    if (scale_q == 4'd0) begin
      s_eff = SW'(1);
    end else if (32'(scale_q) > MAX_SCALE) begin
      s_eff = SW'(MAX_SCALE);
    end else begin
      s_eff = SW'(scale_q);
    end
  end
  assign scale_o = s_eff;

  // Classify the current position
  assign dim16      = bank_q[1];
  assign two_sec    = bank_q[0];
  assign col_last   = dim16 ? (col_q == 4'd15) : (col_q[2:0] == 3'd7);
  assign row_done   = col_last && (!two_sec || sec_q);
  assign rrep_inc   = {1'b0, rrep_q} + (SW+1)'(1);
  assign rrep_last  = rrep_inc >= {1'b0, s_eff};
  assign sheet_done = row_done && (trow_q == 4'd0) && (prow_q == 3'd0) && rrep_last;

  // Advance the position, restart on bank size or scale writes and after the sheet
  always_comb begin
    bank_d   = bank_q;
    scale_d  = scale_q;
    sec_d    = sec_q;
    col_d    = col_q;
    trow_d   = trow_q;
    prow_d   = prow_q;
    rrep_d   = rrep_q;
    restart  = 1'b0;
    trow_top = dim16 ? 4'd15 : 4'd7;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BANK_SIZE: begin
          bank_d  = cfg_data_i[1:0];
          restart = 1'b1;
        end
        REG_SCALE: begin
          scale_d = cfg_data_i;
          restart = 1'b1;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (!col_last) begin
        col_d = col_q + 4'd1;
      end else begin
        col_d = 4'd0;
        if (two_sec && !sec_q) begin
          sec_d = 1'b1;
        end else begin
          sec_d = 1'b0;
          if (!rrep_last) begin
            rrep_d = rrep_inc[SW-1:0];
          end else begin
            rrep_d = '0;
            if (prow_q != 3'd0) begin
              prow_d = prow_q - 3'd1;
            end else begin
              prow_d = 3'd7;
              trow_d = (trow_q != 4'd0) ? trow_q - 4'd1 : trow_top;
            end
          end
        end
      end
      restart = sheet_done;
    end
    if (restart) begin
      sec_d  = 1'b0;
      col_d  = 4'd0;
      trow_d = bank_d[1] ? 4'd15 : 4'd7;
      prow_d = 3'd7;
      rrep_d = '0;
    end
  end

  // Form the address of the next expected row
  assign tile_idx = dim16 ? {sec_d, trow_d, col_d}
                          : {2'b00, sec_d, trow_d[2:0], col_d[2:0]};

  assign push_o               = accept;
  assign entry_o.plane_high   = plane_high_i;
  assign entry_o.plane_low    = plane_low_i;
  assign entry_o.row_end      = row_done;
  assign entry_o.sheet_end    = sheet_done;
  assign entry_o.addr         = {tile_idx, 1'b0, prow_d};

  // Hold configuration and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= BANK_SIZE_RESET;
      scale_q <= SCALE_RESET;
      sec_q   <= 1'b0;
      col_q   <= 4'd0;
      trow_q  <= 4'd15;
      prow_q  <= 3'd7;
      rrep_q  <= '0;
    end else begin
      bank_q  <= bank_d;
      scale_q <= scale_d;
      sec_q   <= sec_d;
      col_q   <= col_d;
      trow_q  <= trow_d;
      prow_q  <= prow_d;
      rrep_q  <= rrep_d;
    end
  end

endmodule

FILE: hdl/ptpb_queue.sv
// Two-entry queue between the front end and the serializer.
module ptpb_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ptpb_pkg::ptpb_entry_t entry_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output ptpb_pkg::ptpb_entry_t entry_o
);
  import ptpb_pkg::*;

  `include "assert_macros.svh"

  ptpb_entry_t slot_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = slot_q[rptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  `ASSERT_CLK(a_count_bound, count_q != 2'd3, "queue fill count out of range")
  `ASSERT_IMPL(a_no_pop_empty, pop_i, count_q != 2'd0, "pop from empty queue")

endmodule

FILE: hdl/ptpb_back.sv
// Back end: expands one tile row into replicated, packed bitmap bytes.
module ptpb_back #(
  parameter int unsigned MAX_SCALE = 10,
  parameter int unsigned SW        = $clog2(MAX_SCALE + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [SW-1:0]                scale_i,
  input  logic                         q_valid_i,
  input  ptpb_pkg::ptpb_entry_t        q_entry_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   packed_byte_o,
  output logic                         last_of_item_o,
  output logic                         row_end_o,
  output logic                         sheet_end_o,
  output logic [ptpb_pkg::ADDR_W-1:0]  next_row_address_o
);
  import ptpb_pkg::*;

  `include "assert_macros.svh"

  logic [2:0]    pix_q, pix_d;
  logic [SW-1:0] rep_q, rep_d;
  logic [2:0]    pix1, pix2;
  logic [SW-1:0] rep1, rep2;
  logic          wrap0, wrap1;
  logic [SW:0]   inc0, inc1;
  logic          emit, last;
  logic [1:0]    px_hi, px_lo;

  logic              out_valid_q;
  logic [7:0]        byte_q;
  logic              last_q, row_end_q, sheet_end_q;
  logic [ADDR_W-1:0] addr_q;

  // Step the pixel/repeat position twice: one step per nibble
  assign inc0  = {1'b0, rep_q} + (SW+1)'(1);
  assign wrap0 = inc0 >= {1'b0, scale_i};
  assign pix1  = wrap0 ? pix_q + 3'd1 : pix_q;
  assign rep1  = wrap0 ? '0 : inc0[SW-1:0];
  assign inc1  = {1'b0, rep1} + (SW+1)'(1);
  assign wrap1 = inc1 >= {1'b0, scale_i};
  assign pix2  = wrap1 ? pix1 + 3'd1 : pix1;
  assign rep2  = wrap1 ? '0 : inc1[SW-1:0];
  assign last  = (pix1 == 3'd7) && wrap1;

  // Pick the two pixels of this byte, MSB first
  assign px_hi = {q_entry_i.plane_high[3'd7 - pix_q], q_entry_i.plane_low[3'd7 - pix_q]}
                 & PIXEL_MASK;
  assign px_lo = {q_entry_i.plane_high[3'd7 - pix1], q_entry_i.plane_low[3'd7 - pix1]}
                 & PIXEL_MASK;

  assign emit  = q_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = emit && last;

  always_comb begin
    pix_d = pix_q;
    rep_d = rep_q;
    if (emit) begin
      pix_d = last ? 3'd0 : pix2;
      rep_d = last ? '0 : rep2;
    end
  end

  // Hold the serializer position and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q       <= 3'd0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pix_q <= pix_d;
      rep_q <= rep_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the output byte and its flags
  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q      <= {(PX_BITS)'(px_hi), (PX_BITS)'(px_lo)};
      last_q      <= last;
      row_end_q   <= last && q_entry_i.row_end;
      sheet_end_q <= last && q_entry_i.sheet_end;
      addr_q      <= q_entry_i.addr;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign packed_byte_o      = byte_q;
  assign last_of_item_o     = last_q;
  assign row_end_o          = row_end_q;
  assign sheet_end_o        = sheet_end_q;
  assign next_row_address_o = addr_q;

  `ASSERT_IMPL(a_row_end_last, out_valid_q && row_end_q, last_q,
               "row end flagged on a byte that is not the last of its item")
  `ASSERT_IMPL(a_sheet_end_row, out_valid_q && sheet_end_q, row_end_q,
               "sheet end flagged without row end")

endmodule

FILE: hdl/planar_tile_to_packed_bitmap.sv
// Top level: converts planar 2-bit tile rows to a packed 4-bit bitmap byte stream.
// An accepted item is stored in the queue; its bytes are then registered in the output register.
// Each item yields 4*scale packed bytes (4 at scale 1); the serializer emits one packed byte per
// cycle while an item is queued and the output is not stalled; a two-entry queue lets input run ahead.
// Reset: 8KB bank (16x16 tiles, 2 sections), scale 1, position at the sheet start,
// queue and output register empty.
module planar_tile_to_packed_bitmap #(
  parameter int unsigned MAX_SCALE = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ptpb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ptpb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       plane_low_i,
  input  logic [7:0]                       plane_high_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       packed_byte_o,
  output logic                             last_of_item_o,
  output logic                             row_end_o,
  output logic                             sheet_end_o,
  output logic [ptpb_pkg::ADDR_W-1:0]      next_row_address_o
);
  import ptpb_pkg::*;

  localparam int unsigned SW = $clog2(MAX_SCALE + 1);

  logic          push, pop, q_full, q_valid;
  ptpb_entry_t   push_entry, head_entry;
  logic [SW-1:0] scale_eff;

  assign cfg_ready_o = 1'b1;

  ptpb_front #(.MAX_SCALE(MAX_SCALE), .SW(SW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .plane_low_i  (plane_low_i),
    .plane_high_i (plane_high_i),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .entry_o      (push_entry),
    .scale_o      (scale_eff)
  );

  ptpb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  ptpb_back #(.MAX_SCALE(MAX_SCALE), .SW(SW)) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .scale_i            (scale_eff),
    .q_valid_i          (q_valid),
    .q_entry_i          (head_entry),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .packed_byte_o      (packed_byte_o),
    .last_of_item_o     (last_of_item_o),
    .row_end_o          (row_end_o),
    .sheet_end_o        (sheet_end_o),
    .next_row_address_o (next_row_address_o)
  );

endmodule

FILE: tb/planar_tile_to_packed_bitmap_tb.sv
// Self-checking testbench for the planar tile row to packed bitmap converter.
module planar_tile_to_packed_bitmap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptpb_pkg::*;

  localparam int unsigned MAX_SCALE      = 10;
  localparam int unsigned CHR_TILE_BYTES = 16;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic [2:0] {
    STEP_ITEM,
    STEP_WR_BANK,
    STEP_WR_SCALE,
    STEP_WR_SPARE2,
    STEP_WR_SPARE3
  } step_kind_e;

  // One directed step: a tile row, or a register write carrying data in lo_or_data
  typedef struct packed {
    step_kind_e kind;
    logic [7:0] lo_or_data;
    logic [7:0] high;
    logic       typed;
    logic [7:0] typed_byte;
  } dir_step_t;

  // One random phase: settings, length and idling mix
  typedef struct packed {
    logic [3:0]  bank_data;
    logic [3:0]  scale_data;
    logic [15:0] items;
    logic [7:0]  gap_pct;
    logic [7:0]  stall_pct;
    logic        mid_drain;
  } phase_t;

  typedef struct packed {
    logic [7:0]        pbyte;
    logic              last;
    logic              row_end;
    logic              sheet_end;
    logic [ADDR_W-1:0] addr;
  } bitmap_byte_t;

  // Uniform and alternating pixel patterns carry their byte value; everything else is predicted
  localparam dir_step_t DIR_STEPS [24] = '{
    '{STEP_ITEM,      8'h00, 8'h00, 1'b1, 8'h00},
    '{STEP_ITEM,      8'hFF, 8'hFF, 1'b1, 8'h33},
    '{STEP_ITEM,      8'hFF, 8'h00, 1'b1, 8'h11},
    '{STEP_ITEM,      8'h00, 8'hFF, 1'b1, 8'h22},
    '{STEP_ITEM,      8'hAA, 8'h55, 1'b1, 8'h12},
    '{STEP_ITEM,      8'h55, 8'hAA, 1'b1, 8'h21},
    '{STEP_ITEM,      8'h80, 8'h01, 1'b0, 8'h00},
    '{STEP_ITEM,      8'h01, 8'h80, 1'b0, 8'h00},
    '{STEP_WR_SCALE,  8'h00, 8'h00, 1'b0, 8'h00},
    '{STEP_ITEM,      8'hFF, 8'hFF, 1'b1, 8'h33},
    '{STEP_ITEM,      8'h0F, 8'hF0, 1'b0, 8'h00},
    '{STEP_WR_SCALE,  8'h0F, 8'h00, 1'b0, 8'h00},
    '{STEP_ITEM,      8'hFF, 8'h00, 1'b1, 8'h11},
    '{STEP_ITEM,      8'h3C, 8'hC3, 1'b0, 8'h00},
    '{STEP_WR_BANK,   8'h0C, 8'h00, 1'b0, 8'h00},
    '{STEP_WR_SCALE,  8'h03, 8'h00, 1'b0, 8'h00},
    '{STEP_ITEM,      8'hA5, 8'h5A, 1'b0, 8'h00},
    '{STEP_ITEM,      8'h00, 8'hFF, 1'b1, 8'h22},
    '{STEP_WR_SPARE2, 8'h07, 8'h00, 1'b0, 8'h00},
    '{STEP_ITEM,      8'h12, 8'h34, 1'b0, 8'h00},
    '{STEP_WR_SPARE3, 8'h0A, 8'h00, 1'b0, 8'h00},
    '{STEP_ITEM,      8'hED, 8'hCB, 1'b0, 8'h00},
    '{STEP_WR_BANK,   8'h01, 8'h00, 1'b0, 8'h00},
    '{STEP_ITEM,      8'hFE, 8'h7F, 1'b0, 8'h00}
  };

  // The first phase runs a long stretch of a small sheet; the last has no idling
  localparam phase_t PHASES [7] = '{
    '{4'd0, 4'd1,  16'd130, 8'd15, 8'd15, 1'b1},
    '{4'd2, 4'd10, 16'd16,  8'd20, 8'd10, 1'b0},
    '{4'd1, 4'd2,  16'd40,  8'd10, 8'd30, 1'b1},
    '{4'd7, 4'd4,  16'd30,  8'd0,  8'd0,  1'b0},
    '{4'd0, 4'd7,  16'd24,  8'd25, 8'd25, 1'b0},
    '{4'd3, 4'd9,  16'd20,  8'd12, 8'd12, 1'b0},
    '{4'd3, 4'd1,  16'd36,  8'd0,  8'd0,  1'b0}
  };

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = REG_BANK_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            plane_low_i  = '0;
  logic [7:0]            plane_high_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [7:0]            packed_byte_o;
  logic                  last_of_item_o;
  logic                  row_end_o;
  logic                  sheet_end_o;
  logic [ADDR_W-1:0]     next_row_address_o;

  // Mirror of the sheet position and settings
  int unsigned bank_code;
  int unsigned scale_reg;
  int unsigned sec_idx;
  int unsigned tile_col;
  int unsigned tile_row;
  int unsigned pix_row;
  int unsigned row_rep;

  bitmap_byte_t expected_bytes [$];
  bitmap_byte_t head_byte;
  int unsigned  error_count = 0;
  int unsigned  gap_pct     = 0;
  int unsigned  stall_pct   = 0;
  int unsigned  stall_left  = 0;

  planar_tile_to_packed_bitmap #(
    .MAX_SCALE(MAX_SCALE)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .plane_low_i       (plane_low_i),
    .plane_high_i      (plane_high_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .packed_byte_o     (packed_byte_o),
    .last_of_item_o    (last_of_item_o),
    .row_end_o         (row_end_o),
    .sheet_end_o       (sheet_end_o),
    .next_row_address_o(next_row_address_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_scale();
    if (scale_reg < 1) return 1;
    if (scale_reg > MAX_SCALE) return MAX_SCALE;
    return scale_reg;
  endfunction

  function automatic int unsigned tiles_per_side();
    return bank_code[1] ? 16 : 8;
  endfunction

  // Move the position back to the sheet start for the current size
  function automatic void restart_sheet();
    sec_idx  = 0;
    tile_col = 0;
    tile_row = tiles_per_side() - 1;
    pix_row  = 7;
    row_rep  = 0;
  endfunction

  function automatic logic [CFG_IDX_W-1:0] reg_for_step(step_kind_e kind);
    case (kind)
      STEP_WR_BANK:   return REG_BANK_SIZE;
      STEP_WR_SCALE:  return REG_SCALE;
      STEP_WR_SPARE2: return REG_SPARE_2;
      default:        return REG_SPARE_3;
    endcase
  endfunction

  function automatic void check_field(string name, logic [ADDR_W-1:0] want,
                                      logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Expand one tile row into packed bytes and advance the sheet position
  function automatic void predict_tile_row(logic [7:0] lo, logic [7:0] hi, logic typed,
                                           logic [7:0] typed_byte);
    int unsigned  s;
    int unsigned  dim;
    int unsigned  secs;
    int unsigned  nbytes;
    int unsigned  n;
    int unsigned  idx;
    logic [1:0]   px;
    logic [7:0]   pk [4*MAX_SCALE];
    logic         row_done;
    logic         sheet_done;
    bitmap_byte_t b;
    s      = eff_scale();
    dim    = tiles_per_side();
    secs   = bank_code[0] ? 2 : 1;
    nbytes = 4 * s;
    foreach (pk[k]) pk[k] = '0;
    for (int i = 0; i < 8; i++) begin
      px = {hi[7-i], lo[7-i]};
      for (int r = 0; r < s; r++) begin
        n = i * s + r;
        if (n % 2 == 0) pk[n/2][7:4] = {2'b00, px};
        else pk[n/2][3:0] = {2'b00, px};
      end
    end
    row_done   = (tile_col + 1 >= dim) && (sec_idx + 1 >= secs);
    sheet_done = row_done && tile_row == 0 && pix_row == 0 && row_rep + 1 >= s;
    // Advance: column, section, row repeat, pixel row, tile row
    if (tile_col + 1 < dim) begin
      tile_col++;
    end else begin
      tile_col = 0;
      if (sec_idx + 1 < secs) begin
        sec_idx++;
      end else begin
        sec_idx = 0;
        if (row_rep + 1 < s) begin
          row_rep++;
        end else begin
          row_rep = 0;
          if (pix_row > 0) begin
            pix_row--;
          end else begin
            pix_row = 7;
            tile_row = (tile_row > 0) ? tile_row - 1 : dim - 1;
          end
        end
      end
    end
    if (sheet_done) restart_sheet();
    idx = tile_col + tile_row * dim + sec_idx * dim * dim;
    for (int k = 0; k < nbytes; k++) begin
      b.pbyte     = typed ? typed_byte : pk[k];
      b.last      = (k + 1 == nbytes);
      b.row_end   = b.last && row_done;
      b.sheet_end = b.last && sheet_done;
      b.addr      = ADDR_W'(idx * CHR_TILE_BYTES + pix_row);
      expected_bytes.push_back(b);
    end
  endfunction

  // Hold the write until the block takes it, mirror it, then drop valid
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_BANK_SIZE: begin
        bank_code = data[1:0];
        restart_sheet();
      end
      REG_SCALE: begin
        scale_reg = data;
        restart_sheet();
      end
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_tile_row(logic [7:0] lo, logic [7:0] hi, logic typed,
                               logic [7:0] typed_byte);
    in_valid_i   <= 1'b1;
    plane_low_i  <= lo;
    plane_high_i <= hi;
    do @(posedge clk_i); while (in_stall_o);
    predict_tile_row(lo, hi, typed, typed_byte);
  endtask

  // Drop valid for a random burst now and then
  task automatic sender_gap();
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Hold off input until every predicted byte is out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_plane();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  // Receiver stalls in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
      stall_left = $urandom_range(1, 17);
    out_stall_i <= (stall_left > 0);
  end

  // Compare each accepted byte with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %02h", packed_byte_o);
        error_count++;
      end else begin
        head_byte = expected_bytes.pop_front();
        check_field("packed_byte", ADDR_W'(head_byte.pbyte), ADDR_W'(packed_byte_o));
        check_field("last_of_item", ADDR_W'(head_byte.last), ADDR_W'(last_of_item_o));
        check_field("row_end", ADDR_W'(head_byte.row_end), ADDR_W'(row_end_o));
        check_field("sheet_end", ADDR_W'(head_byte.sheet_end), ADDR_W'(sheet_end_o));
        check_field("next_row_address", head_byte.addr, next_row_address_o);
      end
    end
  end

  initial begin : stimulus
    phase_t ph;
    bank_code = BANK_SIZE_RESET;
    scale_reg = SCALE_RESET;
    restart_sheet();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed steps first, starting from reset settings
    gap_pct   = 10;
    stall_pct = 10;
    foreach (DIR_STEPS[i]) begin
      if (DIR_STEPS[i].kind == STEP_ITEM) begin
        sender_gap();
        send_tile_row(DIR_STEPS[i].lo_or_data, DIR_STEPS[i].high, DIR_STEPS[i].typed,
                      DIR_STEPS[i].typed_byte);
      end else begin
        wait_drained();
        write_register(reg_for_step(DIR_STEPS[i].kind), DIR_STEPS[i].lo_or_data[3:0]);
      end
    end

    // Random phases, each under fresh settings
    foreach (PHASES[p]) begin
      ph = PHASES[p];
      wait_drained();
      gap_pct   = ph.gap_pct;
      stall_pct = ph.stall_pct;
      write_register(REG_BANK_SIZE, ph.bank_data);
      write_register(REG_SCALE, ph.scale_data);
      for (int n = 0; n < ph.items; n++) begin
        if (ph.mid_drain && n == ph.items / 2) wait_drained();
        sender_gap();
        send_tile_row(pick_plane(), pick_plane(), 1'b0, 8'h00);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("planar_tile_to_packed_bitmap_tb OK");
    end else begin
      $display("planar_tile_to_packed_bitmap_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("planar_tile_to_packed_bitmap_tb NOT OK");
    $finish;
  end

endmodule
